FILE: rtl/core/tmru_pkg.sv
// Package for the tournament tree block: tree sizes, index widths and the
// minimum strength. No dependencies.
`timescale 1ns / 1ps

package tmru_pkg;

  localparam int LEAF_COUNT  = 64;
  localparam int TREE_HEIGHT = 6;
  localparam int NODE_COUNT  = 2 * LEAF_COUNT - 1;

  localparam int NODE_W  = $clog2(NODE_COUNT);
  localparam int LEAF_W  = $clog2(LEAF_COUNT);
  localparam int FILL_W  = $clog2(LEAF_COUNT + 1);
  localparam int LEVEL_W = $clog2(TREE_HEIGHT + 1);
  localparam int DATA_W  = 32;

  localparam logic signed [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_BUILD,
    ST_WALK,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/core/tournament_max_and_runner_up.sv
// A request without last is taken while busy stays low, so such requests can follow back to
// back. A request with last builds the tree, one inner node a cycle through the two-read-port
// node memory, then walks the root path, one level a cycle; done then goes high and the next
// request is taken in the cycle after done. Results cannot be stalled.
// Reset (rst, synchronous): empty tree, no fill, no overflow. Uses tmru_pkg.
`timescale 1ns / 1ps

module tournament_max_and_runner_up (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   start,
  output logic                                   busy,
  input  logic signed [tmru_pkg::DATA_W-1:0]     strength,
  input  logic                                   last,
  output logic                                   done,
  output logic signed [tmru_pkg::DATA_W-1:0]     winner,
  output logic signed [tmru_pkg::DATA_W-1:0]     runner_up,
  output logic                                   overflow
);

  localparam int NW = tmru_pkg::NODE_W;
  localparam int LW = tmru_pkg::LEAF_W;
  localparam int FW = tmru_pkg::FILL_W;
  localparam int HW = tmru_pkg::LEVEL_W;
  localparam int DW = tmru_pkg::DATA_W;

  localparam logic [NW-1:0] FIRST_LEAF = NW'(tmru_pkg::LEAF_COUNT - 1);
  localparam logic [NW-1:0] LAST_INNER = NW'(tmru_pkg::LEAF_COUNT - 2);
  localparam logic [FW-1:0] FILL_FULL  = FW'(tmru_pkg::LEAF_COUNT);
  localparam logic [HW-1:0] LAST_LEVEL = HW'(tmru_pkg::TREE_HEIGHT - 1);

  function automatic logic [NW-1:0] left_child(input logic [NW-1:0] idx);
    return {idx[NW-2:0], 1'b1};
  endfunction

  function automatic logic signed [DW-1:0] larger(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
    return (a > b) ? a : b;
  endfunction

  tmru_pkg::state_t state, state_next;

  logic signed [DW-1:0] mem [tmru_pkg::NODE_COUNT];
  logic signed [DW-1:0] rd_a, rd_b;

  logic                 we;
  logic [NW-1:0]        waddr;
  logic signed [DW-1:0] wdata;
  logic [NW-1:0]        raddr_a, raddr_b;

  logic [FW-1:0]        fill_count, fill_count_next;
  logic                 ovf_seen, ovf_seen_next;
  logic [NW-1:0]        bi, bi_next;
  logic                 iss_done, iss_done_next;
  logic                 rvalid, rvalid_next;
  logic [NW-1:0]        node_q, node_q_next;
  logic [NW-1:0]        widx, widx_next;
  logic [HW-1:0]        lvl, lvl_next;
  logic signed [DW-1:0] win, win_next;
  logic signed [DW-1:0] second, second_next;
  logic [NW-1:0]        ra_a, ra_b;
  logic                 fwd_a, fwd_b;
  logic signed [DW-1:0] fwd_data;

  logic                 leaf_a, leaf_b;
  logic [LW-1:0]        pos_a, pos_b;
  logic signed [DW-1:0] val_a, val_b, node_max;
  logic [NW-1:0]        rd_idx, idx_new;

  // resolve read data: forwarded write, unfilled leaf, or memory
  always_comb begin
    leaf_a   = ra_a >= FIRST_LEAF;
    leaf_b   = ra_b >= FIRST_LEAF;
    pos_a    = LW'(ra_a - FIRST_LEAF);
    pos_b    = LW'(ra_b - FIRST_LEAF);
    if (fwd_a) begin
      val_a = fwd_data;
    end else if (leaf_a && ({1'b0, pos_a} >= fill_count)) begin
      val_a = tmru_pkg::INT_MIN;
    end else begin
      val_a = rd_a;
    end
    if (fwd_b) begin
      val_b = fwd_data;
    end else if (leaf_b && ({1'b0, pos_b} >= fill_count)) begin
      val_b = tmru_pkg::INT_MIN;
    end else begin
      val_b = rd_b;
    end
    node_max = larger(val_a, val_b);
  end

  always_comb begin
    state_next      = state;
    fill_count_next = fill_count;
    ovf_seen_next   = ovf_seen;
    bi_next         = bi;
    iss_done_next   = iss_done;
    rvalid_next     = rvalid;
    node_q_next     = node_q;
    widx_next       = widx;
    lvl_next        = lvl;
    win_next        = win;
    second_next     = second;
    we              = 1'b0;
    waddr           = FIRST_LEAF + NW'(fill_count);
    wdata           = strength;
    rd_idx          = bi;
    idx_new         = ra_b;
    unique case (state)
      tmru_pkg::ST_IDLE: begin
        if (start) begin
          if (fill_count < FILL_FULL) begin
            we              = 1'b1;
            fill_count_next = fill_count + FW'(1);
          end else begin
            ovf_seen_next = 1'b1;
          end
          if (last) begin
            state_next    = tmru_pkg::ST_BUILD;
            bi_next       = LAST_INNER;
            iss_done_next = 1'b0;
            rvalid_next   = 1'b0;
          end
        end
      end
      tmru_pkg::ST_BUILD: begin
        if (rvalid) begin
          we    = 1'b1;
          waddr = node_q;
          wdata = node_max;
          if (node_q == '0) begin
            win_next    = node_max;
            second_next = tmru_pkg::INT_MIN;
            widx_next   = '0;
            lvl_next    = '0;
            state_next  = tmru_pkg::ST_WALK;
          end
        end
        rvalid_next = !iss_done;
        if (!iss_done) begin
          node_q_next = bi;
          if (bi == '0) begin
            iss_done_next = 1'b1;
          end else begin
            bi_next = bi - NW'(1);
          end
        end
      end
      tmru_pkg::ST_WALK: begin
        if (!rvalid) begin
          rd_idx      = widx;
          rvalid_next = 1'b1;
        end else begin
          if (val_a == win) begin
            second_next = larger(second, val_b);
            idx_new     = ra_a;
          end else begin
            second_next = larger(second, val_a);
            idx_new     = ra_b;
          end
          lvl_next  = lvl + HW'(1);
          widx_next = idx_new;
          rd_idx    = idx_new;
          if ((lvl == LAST_LEVEL) || (idx_new >= FIRST_LEAF)) begin
            rvalid_next = 1'b0;
            state_next  = tmru_pkg::ST_DONE;
          end
        end
      end
      tmru_pkg::ST_DONE: begin
        fill_count_next = '0;
        ovf_seen_next   = 1'b0;
        state_next      = tmru_pkg::ST_IDLE;
      end
      default: begin
        state_next = tmru_pkg::ST_IDLE;
      end
    endcase
    raddr_a = left_child(rd_idx);
    raddr_b = left_child(rd_idx) + NW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tmru_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
      ovf_seen   <= 1'b0;
      iss_done   <= 1'b0;
      rvalid     <= 1'b0;
    end else begin
      fill_count <= fill_count_next;
      ovf_seen   <= ovf_seen_next;
      iss_done   <= iss_done_next;
      rvalid     <= rvalid_next;
    end
  end

  always_ff @(posedge clk) begin
    bi       <= bi_next;
    node_q   <= node_q_next;
    widx     <= widx_next;
    lvl      <= lvl_next;
    win      <= win_next;
    second   <= second_next;
    ra_a     <= raddr_a;
    ra_b     <= raddr_b;
    fwd_a    <= we && (waddr == raddr_a);
    fwd_b    <= we && (waddr == raddr_b);
    fwd_data <= wdata;
  end

  // node memory, read-before-write, one write and two read ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_a <= mem[raddr_a];
    rd_b <= mem[raddr_b];
  end

  assign busy      = state != tmru_pkg::ST_IDLE;
  assign done      = state == tmru_pkg::ST_DONE;
  assign winner    = win;
  assign runner_up = second;
  assign overflow  = ovf_seen;

endmodule

FILE: rtl/core/tmru_checker.sv
// Port-level checks for tournament_max_and_runner_up and their bind.
// Watches the handshake ports only; no package dependency.
`timescale 1ns / 1ps

module tmru_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic last,
  input logic done
);

  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("done held for more than one cycle");

  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done while idle");

  a_done_frees: assert property (@(posedge clk) disable iff (rst) done |=> !busy)
    else $error("still busy after result");

  a_plain_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && !last) |=> (!busy && !done))
    else $error("request without last made the block busy");

  a_last_req: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && last) |=> (busy && !done))
    else $error("request with last did not start the tournament");

endmodule

bind tournament_max_and_runner_up tmru_checker u_tmru_checker (.*);

FILE: tb/tb_tournament_max_and_runner_up.sv
// Self-checking testbench for tournament_max_and_runner_up: player groups are
// sent as requests, winner, runner-up and overflow are predicted and compared.
// Depends on tmru_pkg and the tournament_max_and_runner_up RTL.
`timescale 1ns / 1ps

module tb_tournament_max_and_runner_up;
  localparam int LEAF_COUNT  = tmru_pkg::LEAF_COUNT;
  localparam int TREE_HEIGHT = tmru_pkg::TREE_HEIGHT;
  localparam int NODE_COUNT  = tmru_pkg::NODE_COUNT;
  localparam int DATA_W      = tmru_pkg::DATA_W;
  localparam logic signed [DATA_W-1:0] INT_MIN = tmru_pkg::INT_MIN;

  localparam logic signed [DATA_W-1:0] INT_MAX = ~INT_MIN;
  localparam int SETTLE_CYCLES = LEAF_COUNT + TREE_HEIGHT + 16;

  typedef struct {
    logic signed [DATA_W-1:0] winner;
    logic signed [DATA_W-1:0] runner_up;
    logic                     overflow;
  } standings_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     start = 1'b0;
  logic signed [DATA_W-1:0] strength = '0;
  logic                     last = 1'b0;
  logic                     busy;
  logic                     done;
  logic signed [DATA_W-1:0] winner;
  logic signed [DATA_W-1:0] runner_up;
  logic                     overflow;

  logic signed [DATA_W-1:0] roster [LEAF_COUNT];
  int                       roster_fill;
  logic                     roster_overflow;
  standings_t               pending_standings [$];
  int                       mismatch_count = 0;

  tournament_max_and_runner_up uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .strength  (strength),
    .last      (last),
    .done      (done),
    .winner    (winner),
    .runner_up (runner_up),
    .overflow  (overflow)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_roster();
    for (int i = 0; i < LEAF_COUNT; i++) roster[i] = INT_MIN;
    roster_fill = 0;
    roster_overflow = 1'b0;
  endfunction

  function automatic standings_t play_tournament();
    logic signed [DATA_W-1:0] node [NODE_COUNT];
    logic signed [DATA_W-1:0] best;
    logic signed [DATA_W-1:0] second;
    int                       idx;
    int                       lvl;
    standings_t               res;
    for (int i = 0; i < LEAF_COUNT; i++) node[LEAF_COUNT - 1 + i] = roster[i];
    for (int i = LEAF_COUNT - 2; i >= 0; i--)
      node[i] = (node[2*i+1] > node[2*i+2]) ? node[2*i+1] : node[2*i+2];
    best = node[0];
    second = INT_MIN;
    idx = 0;
    lvl = 0;
    while (lvl < TREE_HEIGHT && idx < LEAF_COUNT - 1) begin
      // ties follow the left branch
      if (node[2*idx+1] == best) begin
        if (node[2*idx+2] > second) second = node[2*idx+2];
        idx = 2*idx + 1;
      end else begin
        if (node[2*idx+1] > second) second = node[2*idx+1];
        idx = 2*idx + 2;
      end
      lvl++;
    end
    res.winner = best;
    res.runner_up = second;
    res.overflow = roster_overflow;
    return res;
  endfunction

  function automatic void enter_player(logic signed [DATA_W-1:0] s, logic l);
    if (roster_fill < LEAF_COUNT) begin
      roster[roster_fill] = s;
      roster_fill++;
    end else begin
      roster_overflow = 1'b1;
    end
    if (l) begin
      pending_standings.push_back(play_tournament());
      clear_roster();
    end
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_strength();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 14) return $urandom();
    if (sel < 17) return $signed($urandom_range(0, 4)) - 2;
    case ($urandom_range(0, 3))
      0: return INT_MIN;
      1: return INT_MAX;
      2: return INT_MIN + 1;
      default: return INT_MAX - 1;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic signed [DATA_W-1:0] got,
                                 logic signed [DATA_W-1:0] want);
    $display("%0t: %s got %0d want %0d", $time, what, got, want);
    mismatch_count++;
  endtask

  // Sends one request; start stays high until the next gap or the drain.
  task automatic send_request(logic signed [DATA_W-1:0] s, logic l, bit idle);
    int gap;
    gap = (idle && $urandom_range(0, 3) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    strength <= s;
    last <= l;
    do @(posedge clk); while (busy);
    enter_player(s, l);
  endtask

  task automatic send_group(int size, bit idle);
    for (int i = 0; i < size; i++) send_request(pick_strength(), i == size - 1, idle);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (pending_standings.size() == 0) begin
        report_mismatch("unexpected result, winner", winner, winner);
      end else begin
        standings_t want;
        want = pending_standings.pop_front();
        if (winner !== want.winner) report_mismatch("winner", winner, want.winner);
        if (runner_up !== want.runner_up)
          report_mismatch("runner_up", runner_up, want.runner_up);
        if (overflow !== want.overflow)
          report_mismatch("overflow", DATA_W'(overflow), DATA_W'(want.overflow));
      end
    end
  end

  task automatic test_lone_player();
    send_request(INT_MAX, 1'b1, 1'b1);
    send_request(INT_MIN, 1'b1, 1'b1);
    send_request(0, 1'b1, 1'b1);
  endtask

  task automatic test_extremes();
    send_request(INT_MIN, 1'b0, 1'b1);
    send_request(INT_MAX, 1'b0, 1'b1);
    send_request(-1, 1'b0, 1'b1);
    send_request(0, 1'b0, 1'b1);
    send_request(1, 1'b1, 1'b1);
    send_request(-1, 1'b0, 1'b1);
    send_request(-2, 1'b1, 1'b1);
    // winner in the last of four filled leaves
    send_request(3, 1'b0, 1'b1);
    send_request(1, 1'b0, 1'b1);
    send_request(2, 1'b0, 1'b1);
    send_request(INT_MAX - 1, 1'b1, 1'b1);
  endtask

  task automatic test_ties();
    send_request(5, 1'b0, 1'b1);
    send_request(5, 1'b1, 1'b1);
    send_request(7, 1'b0, 1'b1);
    send_request(3, 1'b0, 1'b1);
    send_request(7, 1'b0, 1'b1);
    send_request(7, 1'b1, 1'b1);
    send_request(INT_MIN, 1'b0, 1'b1);
    send_request(INT_MIN, 1'b1, 1'b1);
  endtask

  task automatic test_random_groups(int target);
    int sent;
    int size;
    int sel;
    sent = 0;
    while (sent < target) begin
      sel = $urandom_range(0, 19);
      if (sel < 12) size = $urandom_range(1, 8);
      else if (sel < 17) size = $urandom_range(9, LEAF_COUNT - 1);
      else if (sel < 19) size = LEAF_COUNT;
      else size = $urandom_range(LEAF_COUNT + 1, LEAF_COUNT + 8);
      send_group(size, 1'b1);
      sent += size;
    end
  endtask

  // Full tree, then a last player with no free leaf.
  task automatic test_overflow_on_last(int groups);
    for (int g = 0; g < groups; g++) begin
      for (int i = 0; i < LEAF_COUNT; i++) send_request(pick_strength(), 1'b0, 1'b1);
      send_request(pick_strength(), 1'b1, 1'b1);
    end
  endtask

  task automatic test_back_to_back(int target);
    int sent;
    int size;
    sent = 0;
    while (sent < target) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(LEAF_COUNT, LEAF_COUNT + 3)
                                         : $urandom_range(1, 10);
      send_group(size, 1'b0);
      sent += size;
    end
  endtask

  initial begin
    clear_roster();
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_lone_player();
    test_extremes();
    test_ties();
    test_random_groups(1000);
    test_overflow_on_last(3);
    test_back_to_back(150);
    start <= 1'b0;
    last <= 1'b0;
    while (pending_standings.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_standings.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
